### src/irt_pkg.sv
// ----------------------------------------------------------------------------
// irt_pkg
// Types and constants shared by the integer-to-radix-text block.
// ----------------------------------------------------------------------------
`default_nettype none
package irt_pkg;

  localparam int InValueW = 64;
  localparam logic [6:0] CharZero  = 7'h30;
  localparam logic [6:0] CharAlpha = 7'h57;  // 'a' - 10
  localparam logic [6:0] CharMinus = 7'h2d;
  localparam logic [5:0] RadixMin  = 6'd2;
  localparam logic [5:0] RadixMax  = 6'd36;
  localparam logic [5:0] RadixDec  = 6'd10;

  typedef struct packed {
    logic [InValueW-1:0] value;
    logic [5:0]          radix;
    logic                signed_mode;
    logic                wide_mode;
  } in_item_t;

  typedef struct packed {
    logic [6:0] character;
    logic       last_char;
    logic [6:0] digit_count;
  } out_item_t;

  // Classified job passed from the front part to the back part.
  typedef struct packed {
    logic [InValueW-1:0] mag;
    logic [5:0]          radix;
    logic                neg;
  } job_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_SIGN,
    ST_EMIT,
    ST_WAIT
  } back_state_t;

  function automatic logic [6:0] digit_char(input logic [5:0] d);
    if (d > 6'd9) digit_char = {1'b0, d} + CharAlpha;
    else          digit_char = {1'b0, d} + CharZero;
  endfunction

endpackage
`default_nettype wire

### src/irt_ram.sv
// ----------------------------------------------------------------------------
// irt_ram
// Generic single-port-write, registered-read RAM.
// ----------------------------------------------------------------------------
`default_nettype none
module irt_ram #(
  parameter int Width = 6,
  parameter int Depth = 64
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(Depth)-1:0] wr_addr,
  input  wire logic [Width-1:0]         wr_data,
  input  wire logic [$clog2(Depth)-1:0] rd_addr,
  output logic [Width-1:0]              rd_data
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    rd_data <= mem[rd_addr];
  end
endmodule
`default_nettype wire

### src/irt_front.sv
// ----------------------------------------------------------------------------
// irt_front
// Accepts items, saturates the radix, selects width and takes the magnitude,
// then pushes the job into a two-entry queue for the back part.
// ----------------------------------------------------------------------------
`default_nettype none
module irt_front
  import irt_pkg::*;
#(
  parameter int ValueWidth = 64
) (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_stall,
  input  wire in_item_t in_data,
  output logic          job_valid,
  output job_t          job,
  input  wire logic     job_pop
);
  job_t                q_r [2];
  logic                rd_ptr_r, wr_ptr_r;
  logic [1:0]          cnt_r;
  logic                push;
  job_t                new_job;
  logic [5:0]          rdx;
  logic [InValueW-1:0] mask, v;
  logic                top_bit;

  assign in_stall = (cnt_r == 2'd2);
  assign push     = in_valid && !in_stall;

  always_comb begin
    mask = in_data.wide_mode ? InValueW'({ValueWidth{1'b1}}) : InValueW'({32{1'b1}});
    v = in_data.value & mask;
    top_bit = in_data.wide_mode ? v[ValueWidth-1] : v[31];
    if (in_data.radix < RadixMin)      rdx = RadixMin;
    else if (in_data.radix > RadixMax) rdx = RadixMax;
    else                               rdx = in_data.radix;
    new_job.radix = rdx;
    new_job.neg   = in_data.signed_mode && (rdx == RadixDec) && top_bit;
    new_job.mag   = new_job.neg ? ((~v + InValueW'(1)) & mask) : v;
  end

  always_ff @(posedge clk) begin
    if (push) q_r[wr_ptr_r] <= new_job;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_ptr_r <= 1'b0;
      wr_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (push) wr_ptr_r <= !wr_ptr_r;
      if (job_pop) rd_ptr_r <= !rd_ptr_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, job_pop};
    end
  end

  assign job_valid = (cnt_r != 2'd0);
  assign job       = q_r[rd_ptr_r];
endmodule
`default_nettype wire

### src/irt_back.sv
// ----------------------------------------------------------------------------
// irt_back
// Bit-serial divider producing one digit per pass; digits are stored in a
// small RAM and replayed most significant first through an output register.
// ----------------------------------------------------------------------------
`default_nettype none
module irt_back
  import irt_pkg::*;
#(
  parameter int MaxDigits = 64
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  job_valid,
  input  wire job_t  job,
  output logic       job_pop,
  output logic       out_valid,
  input  wire logic  out_stall,
  output out_item_t  out_data
);
  localparam int AW = $clog2(MaxDigits);
  localparam int BW = $clog2(InValueW);

  back_state_t         st_r, st_nxt;
  logic [InValueW-1:0] quo_r, quo_nxt;
  logic [5:0]          rem_r, rem_nxt;
  logic [5:0]          rem_step;
  logic [5:0]          radix_r;
  logic                neg_r;
  logic [BW-1:0]       bit_r, bit_nxt;
  logic [6:0]          nd_r, nd_nxt;
  logic [6:0]          idx_r, idx_nxt;
  logic                ov_r, ov_nxt;
  out_item_t           od_r, od_nxt;
  logic                wr_en;
  logic [5:0]          rd_dig;
  logic [6:0]          trial;
  logic                done_div;

  irt_ram #(.Width(6), .Depth(MaxDigits)) u_ram (
    .clk(clk), .wr_en(wr_en), .wr_addr(nd_r[AW-1:0]), .wr_data(rem_step),
    .rd_addr(idx_nxt[AW-1:0]), .rd_data(rd_dig)
  );

  assign trial    = {rem_r, quo_r[InValueW-1]};
  assign done_div = (bit_r == '0);
  assign wr_en    = (st_r == ST_DIV) && done_div;

  // Next-state logic.
  always_comb begin
    st_nxt = st_r;
    case (st_r)
      ST_IDLE: if (job_valid) st_nxt = ST_DIV;
      ST_DIV: begin
        if (done_div && ((quo_nxt == '0) || (nd_r + 7'd1 >= 7'(MaxDigits))))
          st_nxt = neg_r ? ST_SIGN : ST_WAIT;
      end
      ST_SIGN: if (!ov_r || !out_stall) st_nxt = ST_WAIT;
      ST_WAIT: st_nxt = ST_EMIT;
      ST_EMIT: if (!ov_r || !out_stall) begin
        if (idx_r == 7'd0) st_nxt = ST_IDLE;
        else               st_nxt = ST_WAIT;
      end
      default: st_nxt = ST_IDLE;
    endcase
  end

  // Datapath and output logic.
  always_comb begin
    job_pop     = 1'b0;
    quo_nxt     = quo_r;
    rem_nxt     = rem_r;
    rem_step    = rem_r;
    bit_nxt     = bit_r;
    nd_nxt      = nd_r;
    idx_nxt     = idx_r;
    ov_nxt      = ov_r && out_stall;
    od_nxt      = od_r;
    case (st_r)
      ST_IDLE: begin
        if (job_valid) begin
          job_pop = 1'b1;
          quo_nxt = job.mag;
          rem_nxt = '0;
          bit_nxt = BW'(InValueW - 1);
          nd_nxt  = '0;
        end
      end
      ST_DIV: begin
        // One restoring step per cycle; trial never exceeds twice the radix.
        if (trial >= {1'b0, radix_r}) begin
          rem_step = 6'(trial - {1'b0, radix_r});
          quo_nxt  = {quo_r[InValueW-2:0], 1'b1};
        end else begin
          rem_step = trial[5:0];
          quo_nxt  = {quo_r[InValueW-2:0], 1'b0};
        end
        rem_nxt = rem_step;
        bit_nxt = bit_r - BW'(1);
        if (done_div) begin
          nd_nxt  = nd_r + 7'd1;
          idx_nxt = nd_r;
          if (!((quo_nxt == '0) || (nd_r + 7'd1 >= 7'(MaxDigits)))) begin
            rem_nxt = '0;
            bit_nxt = BW'(InValueW - 1);
          end
        end
      end
      ST_SIGN: begin
        if (!ov_r || !out_stall) begin
          ov_nxt = 1'b1;
          od_nxt = '{character: CharMinus, last_char: 1'b0, digit_count: nd_r};
        end
      end
      ST_EMIT: begin
        if (!ov_r || !out_stall) begin
          ov_nxt = 1'b1;
          od_nxt = '{character: digit_char(rd_dig), last_char: (idx_r == 7'd0),
                     digit_count: nd_r};
          if (idx_r != 7'd0) idx_nxt = idx_r - 7'd1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    quo_r <= quo_nxt;
    rem_r <= (wr_en && !(st_nxt == ST_DIV)) ? rem_r : rem_nxt;
    bit_r <= bit_nxt;
    idx_r <= idx_nxt;
    od_r  <= od_nxt;
    if (job_pop) begin
      radix_r <= job.radix;
      neg_r   <= job.neg;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r      <= ST_IDLE;
      ov_r      <= 1'b0;
      nd_r      <= '0;
    end else begin
      st_r      <= st_nxt;
      ov_r      <= ov_nxt;
      nd_r      <= nd_nxt;
    end
  end

  assign out_valid = ov_r;
  assign out_data  = od_r;
endmodule
`default_nettype wire

### src/integer_to_radix_text.sv
// ----------------------------------------------------------------------------
// integer_to_radix_text
// Converts one integer per transaction to its ASCII text in radix 2..36.
// ----------------------------------------------------------------------------
// Usage: present an item on in_data with in_valid; it is taken when in_stall
// is low. Each character of the text leaves on out_data as a transaction of
// its own, most significant digit first, with last_char set on the final one
// and digit_count on all. A '-' leads negative signed decimal values.
// Operation: the front part writes each accepted item into a two-entry queue.
// The back part takes the job, runs a bit-serial restoring divider that
// yields one digit per pass, then replays the digits through a wait and an
// emit state per character, after a leading '-' where there is one.
// Reset clears the queue and the sequencer; nothing else needs clearing.
// When out_stall is high the output register holds its transaction and
// no further character is loaded; the queue keeps accepting until full.
// ----------------------------------------------------------------------------
`default_nettype none
module integer_to_radix_text
  import irt_pkg::*;
#(
  parameter int VALUE_WIDTH = 64,
  parameter int MAX_DIGITS  = 64
) (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_stall,
  input  wire in_item_t in_data,
  output logic          out_valid,
  input  wire logic     out_stall,
  output out_item_t     out_data
);
  logic job_valid, job_pop;
  job_t job;

  irt_front #(.ValueWidth(VALUE_WIDTH)) u_front (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
    .in_data(in_data), .job_valid(job_valid), .job(job), .job_pop(job_pop)
  );

  irt_back #(.MaxDigits(MAX_DIGITS)) u_back (
    .clk(clk), .rst_n(rst_n), .job_valid(job_valid), .job(job),
    .job_pop(job_pop), .out_valid(out_valid), .out_stall(out_stall),
    .out_data(out_data)
  );

  a_pop_needs_job: assert property (@(posedge clk) disable iff (!rst_n)
    job_pop |-> job_valid) else $error("queue popped while empty");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.digit_count != 7'd0)
    else $error("zero digit count on a result");
endmodule
`default_nettype wire
